// File: rtl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int MAX_FRAMES  = 16;
  localparam int PAGE_BITS   = 16;
  localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);

  // field widths of the channels and the register
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(4);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_COMMIT
  } lpr_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } lpr_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lpr_status_t;

endpackage

// File: rtl/lpr_if.sv
`timescale 1ns / 1ps

interface lpr_req_if import lpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lpr_rsp_if import lpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  frame_slot;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] fault_total;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output hit_total, output fault_total, input ready);
  modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                input evicted_page, input hit_total, input fault_total, output ready);
endinterface

// File: rtl/lpr_ctrl.sv
`timescale 1ns / 1ps

module lpr_ctrl import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  lpr_status_t status,
  output lpr_cmd_t    cmd
);

  lpr_state_t state, state_next;
  logic       rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.read = 1'b1;
        if (status.scan_last) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.commit) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

endmodule

// File: rtl/lpr_datapath.sv
`timescale 1ns / 1ps

module lpr_datapath import lpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lpr_cmd_t           cmd,
  output lpr_status_t        status,
  input  logic [PAGE_W-1:0]  page_number,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic               hit,
  output logic [SLOT_W-1:0]  frame_slot,
  output logic               evicted_valid,
  output logic [PAGE_W-1:0]  evicted_page,
  output logic [TOTAL_W-1:0] hit_total,
  output logic [TOTAL_W-1:0] fault_total
);

  logic [CFG_W-1:0]       frames_in_use;
  logic [PAGE_BITS-1:0]   page_mem [MAX_FRAMES];
  logic [PAGE_BITS-1:0]   rd_data;
  logic [MAX_FRAMES-1:0]  frame_valid;
  logic [FRAME_IDX_W-1:0] recency_rank [MAX_FRAMES];
  logic [COUNT_W-1:0]     filled_count;
  logic [TOTAL_W-1:0]     hit_counter;
  logic [TOTAL_W-1:0]     fault_counter;

  logic [PAGE_BITS-1:0]   page;
  logic [COUNT_W-1:0]     n_eff;
  logic [COUNT_W-1:0]     n_clamped;
  logic [FRAME_IDX_W-1:0] rd_idx;
  logic [FRAME_IDX_W-1:0] cmp_idx;
  logic                   cmp_vld;

  logic                   found;
  logic [FRAME_IDX_W-1:0] match_slot;
  logic [FRAME_IDX_W-1:0] match_rank;
  logic [FRAME_IDX_W-1:0] worst_slot;
  logic [FRAME_IDX_W-1:0] worst_rank;
  logic [PAGE_BITS-1:0]   worst_page;

  logic                   cmp_valid_frame;
  logic [FRAME_IDX_W-1:0] cmp_rank;
  logic                   is_fill;
  logic                   age_all;
  logic                   do_write;
  logic [FRAME_IDX_W-1:0] slot_sel;
  logic [FRAME_IDX_W-1:0] old_rank;

  // register value 0 acts as 1, values past the built count as the built count
  always_comb begin
    if (int'(frames_in_use) > MAX_FRAMES) n_clamped = COUNT_W'(MAX_FRAMES);
    else if (frames_in_use == '0) n_clamped = COUNT_W'(1);
    else n_clamped = COUNT_W'(frames_in_use);
  end

  assign status.scan_last = (COUNT_W'(rd_idx) == n_eff - COUNT_W'(1));

  assign cmp_valid_frame = frame_valid[cmp_idx];
  assign cmp_rank        = recency_rank[cmp_idx];

  assign is_fill  = !found && (filled_count < n_eff);
  assign age_all  = is_fill;
  assign do_write = !found;
  assign slot_sel = found ? match_slot :
                    is_fill ? filled_count[FRAME_IDX_W-1:0] : worst_slot;
  assign old_rank = found ? match_rank : worst_rank;

  always_ff @(posedge clk) begin
    if (rst) frames_in_use <= FRAMES_IN_USE_RESET;
    else if (cfg_we) frames_in_use <= cfg_wdata;
  end

  // page store, registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) page_mem[slot_sel] <= page;
    if (cmd.read) rd_data <= page_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) cmp_vld <= 1'b0;
    else cmp_vld <= cmd.read;
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page       <= PAGE_BITS'(page_number);
      n_eff      <= n_clamped;
      rd_idx     <= '0;
      found      <= 1'b0;
      match_slot <= '0;
      match_rank <= '0;
      worst_slot <= '0;
      worst_rank <= '0;
      worst_page <= '0;
    end else begin
      if (cmd.read) begin
        rd_idx  <= rd_idx + FRAME_IDX_W'(1);
        cmp_idx <= rd_idx;
      end
      if (cmp_vld) begin
        // lowest matching frame wins
        if (cmp_valid_frame && rd_data == page && !found) begin
          found      <= 1'b1;
          match_slot <= cmp_idx;
          match_rank <= cmp_rank;
        end
        if (cmp_valid_frame && cmp_rank >= worst_rank) begin
          worst_rank <= cmp_rank;
          worst_slot <= cmp_idx;
          worst_page <= rd_data;
        end
      end
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      filled_count  <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) recency_rank[i] <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (frame_valid[i] && FRAME_IDX_W'(i) != slot_sel &&
            (age_all || recency_rank[i] < old_rank))
          recency_rank[i] <= recency_rank[i] + FRAME_IDX_W'(1);
      end
      recency_rank[slot_sel] <= '0;
      frame_valid[slot_sel]  <= 1'b1;
      if (is_fill) filled_count <= filled_count + COUNT_W'(1);
      if (found) begin
        if (hit_counter != '1) hit_counter <= hit_counter + TOTAL_W'(1);
      end else begin
        if (fault_counter != '1) fault_counter <= fault_counter + TOTAL_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= found;
      frame_slot    <= SLOT_W'(slot_sel);
      evicted_valid <= !found && !is_fill;
      evicted_page  <= (!found && !is_fill) ? PAGE_W'(worst_page) : '0;
      hit_total     <= (found && hit_counter != '1) ? hit_counter + TOTAL_W'(1)
                                                    : hit_counter;
      fault_total   <= (!found && fault_counter != '1) ? fault_counter + TOTAL_W'(1)
                                                       : fault_counter;
    end
  end

endmodule

// File: rtl/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// lru page replacement core
// operation: the request is loaded, then the n managed frames are scanned one frame a cycle
//   through the page store read port, n = managed frames; a tail state and a commit state
//   follow, and no new request is taken until the result is committed
// reset: synchronous active-high rst clears frames, recency, counts; frames_in_use = 4

module lru_page_replacement_core import lpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lpr_req_if.sink          req,
  lpr_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  lpr_cmd_t    cmd;
  lpr_status_t status;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .page_number   (req.page_number),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .hit           (rsp.hit),
    .frame_slot    (rsp.frame_slot),
    .evicted_valid (rsp.evicted_valid),
    .evicted_page  (rsp.evicted_page),
    .hit_total     (rsp.hit_total),
    .fault_total   (rsp.fault_total)
  );

endmodule
